FILE: sv/moravec_corner_detector_defines.svh
// Assertion macros used by the corner detector queue.
`ifndef MORAVEC_CORNER_DETECTOR_DEFINES_SVH
`define MORAVEC_CORNER_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mcd_pkg.sv
// Shared types and constants of the corner detector.
package mcd_pkg;

  localparam int WINDOW_SIZE_DEF = 10;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT      = 4096;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

  localparam logic [10:0] WIDTH_RESET     = 11'd640;
  localparam logic [12:0] HEIGHT_RESET    = 13'd480;
  localparam logic [19:0] THRESHOLD_RESET = 20'd500;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [19:0] interest_threshold;
  } cfg_t;

endpackage

FILE: sv/mcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: sv/mcd_front.sv
// Front end: pixel position tracking, line memories and the pixel window.
module mcd_front #(
  parameter int WINDOW_SIZE = mcd_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_WIDTH   = mcd_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mcd_pkg::cfg_t                          cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             pixel,
  input  logic                                   frame_start,
  input  logic [$clog2(mcd_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                                   job_valid,
  output logic [3:0][2*(WINDOW_SIZE/2):0][7:0]   job_taps,
  output logic [9:0]                             job_col,
  output logic [11:0]                            job_row
);

  localparam int R    = WINDOW_SIZE / 2;
  localparam int D2   = 2 * R;
  localparam int SPAN = D2 + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int SW   = $clog2(SPAN);
  localparam int QCW  = $clog2(mcd_pkg::QUEUE_DEPTH + 1);

  logic [WW-1:0]  w_raw, eff_w;
  logic [12:0]    eff_h;

  logic           clr_busy_r;
  logic [CW-1:0]  clr_addr_r;

  logic [CW-1:0]  col_r, col_nxt;
  logic [11:0]    row_r, row_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;

  logic [CW-1:0]  cur_col;
  logic [12:0]    cur_row;
  logic [SW-1:0]  cur_slot;
  logic           cur_inner;
  logic           acc;
  logic [QCW:0]   occ;

  logic           s1_v_r, s1_inner_r;
  logic [7:0]     s1_pix_r;
  logic [SW-1:0]  s1_slot_r;
  logic [CW-1:0]  s1_col_r;
  logic [11:0]    s1_row_r;

  logic           s2_v_r;
  logic [9:0]     s2_col_r;
  logic [11:0]    s2_row_r;

  logic [SPAN-1:0][7:0]            ram_q;
  logic [SPAN-1:0][7:0]            colv;
  logic [SPAN-1:0][SPAN-1:0][7:0]  win_r, win_nxt;

  // Effective frame size: zero counts as one, large values saturate.
  assign w_raw = WW'(cfg.image_width);
  always_comb begin
    if (w_raw == '0) begin
      eff_w = WW'(1);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = w_raw;
    end
    if (cfg.image_height == '0) begin
      eff_h = 13'd1;
    end else if (cfg.image_height > 13'(mcd_pkg::MAX_HEIGHT)) begin
      eff_h = 13'(mcd_pkg::MAX_HEIGHT);
    end else begin
      eff_h = cfg.image_height;
    end
  end

  // Each in-flight item holds a queue slot so the front never has to stall.
  assign occ = {1'b0, q_count} + (QCW+1)'(s1_v_r) + (QCW+1)'(s2_v_r);
  assign in_ready = !clr_busy_r && (occ < (QCW+1)'(mcd_pkg::QUEUE_DEPTH));
  assign acc = in_valid && in_ready;

  always_comb begin
    logic [CW-1:0] c0;
    logic [12:0]   r0;
    logic [SW-1:0] s0;
    logic [12:0]   rn;
    c0 = frame_start ? '0 : col_r;
    r0 = frame_start ? '0 : {1'b0, row_r};
    s0 = frame_start ? '0 : slot_r;
    cur_col  = c0;
    cur_row  = r0;
    cur_slot = s0;
    if (WW'(c0) >= eff_w) begin
      cur_col  = '0;
      cur_row  = r0 + 13'd1;
      cur_slot = (s0 == SW'(SPAN - 1)) ? '0 : s0 + SW'(1);
    end
    if (cur_row >= eff_h) begin
      cur_row  = '0;
      cur_slot = '0;
    end
    cur_inner = (cur_row >= 13'(D2)) && (WW'(cur_col) >= WW'(D2));

    rn       = cur_row + 13'd1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (acc) begin
      if (WW'(cur_col) + WW'(1) >= eff_w) begin
        col_nxt = '0;
        if (rn >= eff_h) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = rn[11:0];
          slot_nxt = (cur_slot == SW'(SPAN - 1)) ? '0 : cur_slot + SW'(1);
        end
      end else begin
        col_nxt  = cur_col + CW'(1);
        row_nxt  = cur_row[11:0];
        slot_nxt = cur_slot;
      end
    end
  end

  // One line memory per window row; the row slot rotates with the image row.
  for (genvar j = 0; j < SPAN; j++) begin : g_line
    mcd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (clr_busy_r || (acc && (cur_slot == SW'(j)))),
      .waddr (clr_busy_r ? clr_addr_r : cur_col),
      .wdata (clr_busy_r ? 8'd0 : pixel),
      .re    (acc),
      .raddr (cur_col),
      .rdata (ram_q[j])
    );
  end

  // The column entering the window, oldest row first.
  always_comb begin
    logic [SW:0] idx;
    for (int dy = 0; dy < D2; dy++) begin
      idx = (SW+1)'(s1_slot_r) + (SW+1)'(dy + 1);
      if (idx >= (SW+1)'(SPAN)) begin
        idx = idx - (SW+1)'(SPAN);
      end
      colv[dy] = ram_q[idx[SW-1:0]];
    end
    colv[D2] = s1_pix_r;
  end

  always_comb begin
    win_nxt = win_r;
    if (s1_v_r) begin
      for (int dy = 0; dy < SPAN; dy++) begin
        for (int dx = 0; dx < D2; dx++) begin
          win_nxt[dy][dx] = win_r[dy][dx+1];
        end
        win_nxt[dy][D2] = colv[dy];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      slot_r     <= '0;
      s1_v_r     <= 1'b0;
      s1_inner_r <= 1'b0;
      s2_v_r     <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + CW'(1);
        if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      slot_r     <= slot_nxt;
      s1_v_r     <= acc;
      s1_inner_r <= acc && cur_inner;
      s2_v_r     <= s1_v_r && s1_inner_r;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (acc) begin
      s1_pix_r  <= pixel;
      s1_slot_r <= cur_slot;
      s1_col_r  <= cur_col;
      s1_row_r  <= cur_row[11:0];
    end
    if (s1_v_r) begin
      s2_col_r <= 10'(s1_col_r - CW'(R));
      s2_row_r <= s1_row_r - 12'(R);
    end
  end

  // Taps: center row, center column, main diagonal, anti-diagonal.
  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      job_taps[0][i] = win_r[R][i];
      job_taps[1][i] = win_r[i][R];
      job_taps[2][i] = win_r[i][i];
      job_taps[3][i] = win_r[i][D2-i];
    end
  end

  assign job_valid = s2_v_r;
  assign job_col   = s2_col_r;
  assign job_row   = s2_row_r;

endmodule

FILE: sv/mcd_queue.sv
// Short first-in first-out queue between the front end and the back end.
`include "moravec_corner_detector_defines.svh"
module mcd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcd_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             head,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  `MCD_ASSERT_NOW(a_no_overflow, push, (count_r != CNW'(DEPTH)) || pop, "queue overflow")
  `MCD_ASSERT_NOW(a_no_underflow, pop, count_r != '0, "queue underflow")
  `MCD_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CNW'(1),
                   "queue count did not advance on a lone push")

endmodule

FILE: sv/mcd_back.sv
// Back end: squared differences, directional sums, minimum and threshold.
module mcd_back #(
  parameter int WINDOW_SIZE = mcd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [19:0]                           threshold,
  input  logic                                  job_valid,
  output logic                                  job_pop,
  input  logic [3:0][2*(WINDOW_SIZE/2):0][7:0]  job_taps,
  input  logic [9:0]                            job_col,
  input  logic [11:0]                           job_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [9:0]                            center_column,
  output logic [11:0]                           center_row,
  output logic [19:0]                           interest,
  output logic                                  is_corner
);

  localparam int D2 = 2 * (WINDOW_SIZE / 2);

  logic rdy_out, rdy2, rdy1;

  logic                       b1_v_r;
  logic [3:0][D2-1:0][15:0]   sq_r;
  logic [9:0]                 b1_col_r;
  logic [11:0]                b1_row_r;

  logic                       b2_v_r;
  logic [3:0][19:0]           sum_r;
  logic [9:0]                 b2_col_r;
  logic [11:0]                b2_row_r;

  logic                       out_v_r;
  logic [9:0]                 out_col_r;
  logic [11:0]                out_row_r;
  logic [19:0]                out_int_r;
  logic                       out_corner_r;

  logic [3:0][D2-1:0][15:0]   sq_nxt;
  logic [3:0][19:0]           sum_nxt;
  logic [19:0]                min_nxt;

  // Each stage advances when the next one is empty or moving on.
  assign rdy_out = !out_v_r || out_ready;
  assign rdy2    = !b2_v_r || rdy_out;
  assign rdy1    = !b1_v_r || rdy2;
  assign job_pop = job_valid && rdy1;

  always_comb begin
    logic [7:0] a, b, d;
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < D2; i++) begin
        a = job_taps[l][i];
        b = job_taps[l][i+1];
        d = (a > b) ? a - b : b - a;
        sq_nxt[l][i] = 16'(d) * 16'(d);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sum_nxt[l] = '0;
      for (int i = 0; i < D2; i++) begin
        sum_nxt[l] = sum_nxt[l] + 20'(sq_r[l][i]);
      end
    end
  end

  always_comb begin
    min_nxt = sum_r[0];
    for (int l = 1; l < 4; l++) begin
      if (sum_r[l] < min_nxt) begin
        min_nxt = sum_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        b1_v_r <= job_valid;
      end
      if (rdy2) begin
        b2_v_r <= b1_v_r;
      end
      if (rdy_out) begin
        out_v_r <= b2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      sq_r     <= sq_nxt;
      b1_col_r <= job_col;
      b1_row_r <= job_row;
    end
    if (b1_v_r && rdy2) begin
      sum_r    <= sum_nxt;
      b2_col_r <= b1_col_r;
      b2_row_r <= b1_row_r;
    end
    if (b2_v_r && rdy_out) begin
      out_col_r    <= b2_col_r;
      out_row_r    <= b2_row_r;
      out_int_r    <= min_nxt;
      out_corner_r <= min_nxt > threshold;
    end
  end

  assign out_valid     = out_v_r;
  assign center_column = out_col_r;
  assign center_row    = out_row_r;
  assign interest      = out_int_r;
  assign is_corner     = out_corner_r;

endmodule

FILE: sv/moravec_corner_detector.sv
// Top level of the streaming Moravec corner detector.
// Pixels arrive in raster order, one per transfer, and the block takes one pixel every clock cycle
// while in_tready is high; each window centre at least WINDOW_SIZE/2 from every border yields one
// result, which passes the window registers, the queue and the back-end registers to out_tvalid.
// After reset the line memories are cleared one column per cycle, so the input stays not ready
// until all MAX_WIDTH columns (1024 by default) are cleared; configuration writes are taken during
// that time. Results stall only on out_tready: a four-entry queue between the window front end and
// the arithmetic back end absorbs the pipeline, and the input holds off once it is full.
module moravec_corner_detector #(
  parameter int WINDOW_SIZE = mcd_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_WIDTH   = mcd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [9:0] center_column, [21:10] center_row, [41:22] interest
  output logic        out_tuser,  // [0] is_corner
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);

  localparam int SPAN  = 2 * (WINDOW_SIZE / 2) + 1;
  localparam int TAPW  = 4 * SPAN * 8;
  localparam int QW    = TAPW + 22;
  localparam int QCW   = $clog2(mcd_pkg::QUEUE_DEPTH + 1);

  mcd_pkg::cfg_t cfg_r;

  logic                        job_valid, job_pop, q_empty;
  logic [3:0][SPAN-1:0][7:0]   job_taps, q_taps;
  logic [9:0]                  job_col;
  logic [11:0]                 job_row;
  logic [QW-1:0]               q_head;
  logic [QCW-1:0]              q_count;
  logic [9:0]                  center_column;
  logic [11:0]                 center_row;
  logic [19:0]                 interest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width        <= mcd_pkg::WIDTH_RESET;
      cfg_r.image_height       <= mcd_pkg::HEIGHT_RESET;
      cfg_r.interest_threshold <= mcd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcd_pkg::CFG_IMAGE_WIDTH:  cfg_r.image_width        <= cfg_wdata[10:0];
        mcd_pkg::CFG_IMAGE_HEIGHT: cfg_r.image_height       <= cfg_wdata[12:0];
        mcd_pkg::CFG_THRESHOLD:    cfg_r.interest_threshold <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mcd_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pixel       (in_tdata),
    .frame_start (in_tuser),
    .q_count     (q_count),
    .job_valid   (job_valid),
    .job_taps    (job_taps),
    .job_col     (job_col),
    .job_row     (job_row)
  );

  mcd_queue #(
    .WIDTH (QW),
    .DEPTH (mcd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data ({job_row, job_col, job_taps}),
    .pop       (job_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  assign q_taps = q_head[TAPW-1:0];

  mcd_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .threshold     (cfg_r.interest_threshold),
    .job_valid     (!q_empty),
    .job_pop       (job_pop),
    .job_taps      (q_taps),
    .job_col       (q_head[TAPW+9:TAPW]),
    .job_row       (q_head[TAPW+21:TAPW+10]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .center_column (center_column),
    .center_row    (center_row),
    .interest      (interest),
    .is_corner     (out_tuser)
  );

  assign out_tdata = {6'd0, interest, center_row, center_column};

endmodule
